FILE: sv/nsc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsc_pkg
// Shared sizes, register codes, reset values, reciprocal constants and the
// arrow cursor bitmap of the nearest-neighbor scaler.
// ----------------------------------------------------------------------------
package nsc_pkg;

    // frame store geometry
    localparam int MAX_SRC_W = 1024;
    localparam int MAX_SRC_H = 1024;
    localparam int COL_W     = $clog2(MAX_SRC_W);
    localparam int ROW_W     = $clog2(MAX_SRC_H);
    localparam int ADDR_W    = COL_W + ROW_W;
    localparam int DEPTH     = MAX_SRC_W * MAX_SRC_H;

    // destination geometry
    localparam int DST_W = 876;
    localparam int DST_H = 700;

    // field widths
    localparam int SIZE_W = 11;
    localparam int CRD_W  = 10;
    localparam int PIX_W  = 32;
    localparam int IDX_W  = 3;

    // scaled coordinate product and reciprocal multiply
    localparam int PROD_W    = CRD_W + SIZE_W;
    localparam int MUL_W     = 2 * PROD_W + 1;
    localparam int SHIFT_X   = PROD_W + $clog2(DST_W);
    localparam int SHIFT_Y   = PROD_W + $clog2(DST_H);
    localparam int QUO_X_W   = MUL_W - SHIFT_X;
    localparam int QUO_Y_W   = MUL_W - SHIFT_Y;
    localparam logic [63:0] RECIP_X =
        ((64'd1 << SHIFT_X) + 64'(DST_W) - 64'd1) / 64'(DST_W);
    localparam logic [63:0] RECIP_Y =
        ((64'd1 << SHIFT_Y) + 64'(DST_H) - 64'd1) / 64'(DST_H);

    // accept to result strobe, in clock edges
    localparam int PIPE_LAT = 5;

    // cursor overlay
    localparam int ARROW_SIZE = 14;
    localparam int ARROW_IW   = $clog2(ARROW_SIZE);
    localparam logic [PIX_W-1:0] WHITE_RGBA = '1;

    // register reset values
    localparam logic [SIZE_W-1:0] RST_SRC_W     = SIZE_W'(876);
    localparam logic [SIZE_W-1:0] RST_SRC_H     = SIZE_W'(700);
    localparam logic              RST_CURSOR_ON = 1'b1;
    localparam logic [CRD_W-1:0]  RST_CURSOR_X  = CRD_W'(438);
    localparam logic [CRD_W-1:0]  RST_CURSOR_Y  = CRD_W'(350);

    // register indexes
    typedef enum logic [IDX_W-1:0] {
        CFG_SRC_W     = 3'd0,
        CFG_SRC_H     = 3'd1,
        CFG_CURSOR_ON = 3'd2,
        CFG_CURSOR_X  = 3'd3,
        CFG_CURSOR_Y  = 3'd4
    } t_cfg_idx;

    // effective configuration seen by the datapath
    typedef struct packed {
        logic [SIZE_W-1:0] w;
        logic [SIZE_W-1:0] h;
        logic              cursor_on;
        logic [CRD_W-1:0]  cursor_x;
        logic [CRD_W-1:0]  cursor_y;
    } t_cfg;

    // frame store access issued by the coordinate pipeline
    typedef struct packed {
        logic              rd;
        logic              wr;
        logic [ADDR_W-1:0] addr;
        logic [PIX_W-1:0]  wdata;
        logic [SIZE_W-1:0] sx;
        logic [SIZE_W-1:0] top_row;
    } t_req;

    // one row of the arrow bitmap, bit n is column n
    function automatic logic [ARROW_SIZE-1:0] arrow_row(input logic [ARROW_IW-1:0] row);
        logic [ARROW_SIZE-1:0] bits;
        unique case (row)
            4'd0:    bits = 14'h0001;
            4'd1:    bits = 14'h0003;
            4'd2:    bits = 14'h0007;
            4'd3:    bits = 14'h000F;
            4'd4:    bits = 14'h001F;
            4'd5:    bits = 14'h003F;
            4'd6:    bits = 14'h007F;
            4'd7:    bits = 14'h00FF;
            4'd8:    bits = 14'h01FF;
            4'd9:    bits = 14'h003F;
            4'd10:   bits = 14'h0067;
            4'd11:   bits = 14'h00C3;
            4'd12:   bits = 14'h0180;
            4'd13:   bits = 14'h0080;
            default: bits = '0;
        endcase
        return bits;
    endfunction

endpackage

FILE: sv/nsc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsc_ram
// Generic single-port synchronous RAM, one access per cycle, registered read.
// ----------------------------------------------------------------------------
module nsc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write or registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/nsc_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsc_regs
// Configuration registers with the effective source size clamp.
// ----------------------------------------------------------------------------
module nsc_regs (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_we,
    input  logic [nsc_pkg::IDX_W-1:0]  i_idx,
    input  logic [nsc_pkg::SIZE_W-1:0] i_data,
    output nsc_pkg::t_cfg              o_cfg
);

    logic [nsc_pkg::SIZE_W-1:0] r_src_w;
    logic [nsc_pkg::SIZE_W-1:0] r_src_h;
    logic                       r_cursor_on;
    logic [nsc_pkg::CRD_W-1:0]  r_cursor_x;
    logic [nsc_pkg::CRD_W-1:0]  r_cursor_y;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w     <= nsc_pkg::RST_SRC_W;
            r_src_h     <= nsc_pkg::RST_SRC_H;
            r_cursor_on <= nsc_pkg::RST_CURSOR_ON;
            r_cursor_x  <= nsc_pkg::RST_CURSOR_X;
            r_cursor_y  <= nsc_pkg::RST_CURSOR_Y;
        end else if (i_we) begin
            unique case (nsc_pkg::t_cfg_idx'(i_idx))
                nsc_pkg::CFG_SRC_W:     r_src_w     <= i_data;
                nsc_pkg::CFG_SRC_H:     r_src_h     <= i_data;
                nsc_pkg::CFG_CURSOR_ON: r_cursor_on <= i_data[0];
                nsc_pkg::CFG_CURSOR_X:  r_cursor_x  <= i_data[nsc_pkg::CRD_W-1:0];
                nsc_pkg::CFG_CURSOR_Y:  r_cursor_y  <= i_data[nsc_pkg::CRD_W-1:0];
                default: ;
            endcase
        end
    end

    // zero size reads as one, oversize as the frame store limit
    always_comb begin
        o_cfg.w = r_src_w;
        if (r_src_w == '0) begin
            o_cfg.w = nsc_pkg::SIZE_W'(1);
        end else if (32'(r_src_w) > 32'(nsc_pkg::MAX_SRC_W)) begin
            o_cfg.w = nsc_pkg::SIZE_W'(nsc_pkg::MAX_SRC_W);
        end
        o_cfg.h = r_src_h;
        if (r_src_h == '0) begin
            o_cfg.h = nsc_pkg::SIZE_W'(1);
        end else if (32'(r_src_h) > 32'(nsc_pkg::MAX_SRC_H)) begin
            o_cfg.h = nsc_pkg::SIZE_W'(nsc_pkg::MAX_SRC_H);
        end
        o_cfg.cursor_on = r_cursor_on;
        o_cfg.cursor_x  = r_cursor_x;
        o_cfg.cursor_y  = r_cursor_y;
    end

endmodule

FILE: sv/nsc_map.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsc_map
// Coordinate pipeline: scales destination coordinates to source pixels by
// reciprocal multiply, flips rows, clamps, and issues frame store accesses
// in arrival order. Writes travel the same stages to keep ordering.
// ----------------------------------------------------------------------------
module nsc_map (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_accept,
    input  logic                      i_cmd,
    input  logic [nsc_pkg::CRD_W-1:0] i_src_col,
    input  logic [nsc_pkg::CRD_W-1:0] i_src_row,
    input  logic [nsc_pkg::PIX_W-1:0] i_pixel_in,
    input  logic [nsc_pkg::CRD_W-1:0] i_dst_x,
    input  logic [nsc_pkg::CRD_W-1:0] i_dst_y,
    input  nsc_pkg::t_cfg             i_cfg,
    output nsc_pkg::t_req             o_req
);

    // stage 1: products
    logic                         r_s1_rd;
    logic                         r_s1_wr;
    logic [nsc_pkg::ADDR_W-1:0]   r_s1_waddr;
    logic [nsc_pkg::PIX_W-1:0]    r_s1_wdata;
    logic [nsc_pkg::PROD_W-1:0]   r_s1_px;
    logic [nsc_pkg::PROD_W-1:0]   r_s1_py;
    logic                         r_s1_dy_out;
    // stage 2: quotients
    logic                         r_s2_rd;
    logic                         r_s2_wr;
    logic [nsc_pkg::ADDR_W-1:0]   r_s2_waddr;
    logic [nsc_pkg::PIX_W-1:0]    r_s2_wdata;
    logic [nsc_pkg::QUO_X_W-1:0]  r_s2_qx;
    logic [nsc_pkg::QUO_Y_W-1:0]  r_s2_qy;
    logic                         r_s2_dy_out;
    // stage 3: access request
    nsc_pkg::t_req                r_req;

    logic                         dy_out;
    logic [nsc_pkg::CRD_W-1:0]    dy_flip;
    logic                         wr_ok;
    logic [nsc_pkg::MUL_W-1:0]    mul_x;
    logic [nsc_pkg::MUL_W-1:0]    mul_y;
    logic [nsc_pkg::SIZE_W-1:0]   sx;
    logic [nsc_pkg::SIZE_W-1:0]   sy;

    // row flip and write window check
    always_comb begin
        dy_out  = 32'(i_dst_y) >= 32'(nsc_pkg::DST_H);
        dy_flip = nsc_pkg::CRD_W'(nsc_pkg::DST_H - 1) - i_dst_y;
        wr_ok   = (32'(i_src_col) < 32'(i_cfg.w)) && (32'(i_src_row) < 32'(i_cfg.h));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_rd <= 1'b0;
            r_s1_wr <= 1'b0;
        end else begin
            r_s1_rd <= i_accept && i_cmd;
            r_s1_wr <= i_accept && !i_cmd && wr_ok;
        end
        r_s1_waddr  <= {nsc_pkg::ROW_W'(i_src_row), nsc_pkg::COL_W'(i_src_col)};
        r_s1_wdata  <= i_pixel_in;
        r_s1_px     <= nsc_pkg::PROD_W'(i_dst_x) * nsc_pkg::PROD_W'(i_cfg.w);
        r_s1_py     <= nsc_pkg::PROD_W'(dy_flip) * nsc_pkg::PROD_W'(i_cfg.h);
        r_s1_dy_out <= dy_out;
    end

    // divide by destination size as multiply by rounded-up reciprocal
    assign mul_x = nsc_pkg::MUL_W'(r_s1_px) * nsc_pkg::MUL_W'(nsc_pkg::RECIP_X);
    assign mul_y = nsc_pkg::MUL_W'(r_s1_py) * nsc_pkg::MUL_W'(nsc_pkg::RECIP_Y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_rd <= 1'b0;
            r_s2_wr <= 1'b0;
        end else begin
            r_s2_rd <= r_s1_rd;
            r_s2_wr <= r_s1_wr;
        end
        r_s2_waddr  <= r_s1_waddr;
        r_s2_wdata  <= r_s1_wdata;
        r_s2_qx     <= mul_x[nsc_pkg::SHIFT_X +: nsc_pkg::QUO_X_W];
        r_s2_qy     <= mul_y[nsc_pkg::SHIFT_Y +: nsc_pkg::QUO_Y_W];
        r_s2_dy_out <= r_s1_dy_out;
    end

    // clamp to source, rows below the destination map to the bottom row
    always_comb begin
        if (32'(r_s2_qx) >= 32'(i_cfg.w)) begin
            sx = i_cfg.w - nsc_pkg::SIZE_W'(1);
        end else begin
            sx = nsc_pkg::SIZE_W'(r_s2_qx);
        end
        if (r_s2_dy_out) begin
            sy = '0;
        end else if (32'(r_s2_qy) >= 32'(i_cfg.h)) begin
            sy = i_cfg.h - nsc_pkg::SIZE_W'(1);
        end else begin
            sy = nsc_pkg::SIZE_W'(r_s2_qy);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req.rd <= 1'b0;
            r_req.wr <= 1'b0;
        end else begin
            r_req.rd <= r_s2_rd;
            r_req.wr <= r_s2_wr;
        end
        r_req.addr    <= r_s2_wr ? r_s2_waddr
                                 : {nsc_pkg::ROW_W'(sy), nsc_pkg::COL_W'(sx)};
        r_req.wdata   <= r_s2_wdata;
        r_req.sx      <= sx;
        r_req.top_row <= i_cfg.h - nsc_pkg::SIZE_W'(1) - sy;
    end

    assign o_req = r_req;

endmodule

FILE: sv/nsc_out.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsc_out
// Cursor hit test alongside the frame store read, then the output register
// that picks white or the stored pixel.
// ----------------------------------------------------------------------------
module nsc_out (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  nsc_pkg::t_req             i_req,
    input  nsc_pkg::t_cfg             i_cfg,
    input  logic [nsc_pkg::PIX_W-1:0] i_rdata,
    output logic                      o_valid,
    output logic [nsc_pkg::PIX_W-1:0] o_pixel_out,
    output logic                      o_from_cursor
);

    logic                          r_rd;
    logic                          r_cur;
    logic                          r_valid;
    logic [nsc_pkg::PIX_W-1:0]     r_pixel;
    logic                          r_from_cur;

    logic [nsc_pkg::SIZE_W:0]      dcol;
    logic [nsc_pkg::SIZE_W:0]      drow;
    logic                          in_box;
    logic [nsc_pkg::ARROW_SIZE-1:0] row_bits;
    logic                          hit;

    // offset from the cursor corner, top bit set when left of or above it
    always_comb begin
        dcol     = {1'b0, i_req.sx} - (nsc_pkg::SIZE_W + 1)'(i_cfg.cursor_x);
        drow     = {1'b0, i_req.top_row} - (nsc_pkg::SIZE_W + 1)'(i_cfg.cursor_y);
        in_box   = !dcol[nsc_pkg::SIZE_W] && !drow[nsc_pkg::SIZE_W]
                   && (32'(dcol) < 32'(nsc_pkg::ARROW_SIZE))
                   && (32'(drow) < 32'(nsc_pkg::ARROW_SIZE));
        row_bits = nsc_pkg::arrow_row(drow[nsc_pkg::ARROW_IW-1:0]);
        hit      = i_cfg.cursor_on && in_box && row_bits[dcol[nsc_pkg::ARROW_IW-1:0]];
    end

    // hit registered with the memory read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd <= 1'b0;
        end else begin
            r_rd <= i_req.rd;
        end
        r_cur <= hit;
    end

    // output word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= r_rd;
        end
        r_pixel    <= r_cur ? nsc_pkg::WHITE_RGBA : i_rdata;
        r_from_cur <= r_cur;
    end

    assign o_valid       = r_valid;
    assign o_pixel_out   = r_pixel;
    assign o_from_cursor = r_from_cur;

endmodule

FILE: sv/nearest_scaler_with_cursor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_scaler_with_cursor
// Nearest-neighbor scaler over a bottom-up source frame store, with an arrow
// cursor overlay.
// ----------------------------------------------------------------------------
// One word is taken every clock: busy stays low and start may be held high.
// A write word stores its pixel if it lies inside the source and gives no
// result; a read word gives its result on o_pixel_out / o_from_cursor with
// o_valid high for one cycle, once it has passed two multiply stages for the
// scaling, a clamp stage, the frame store read and the output register. The
// receiver cannot hold results off. The frame store is a single-port 1M x 32
// RAM that serves one write or one read per cycle in arrival order, so a read
// always sees every earlier write. Its contents are undefined until written
// and it has no clearing pass: read only entries that were written.
// ----------------------------------------------------------------------------
module nearest_scaler_with_cursor (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       i_cmd,
    input  logic [nsc_pkg::CRD_W-1:0]  i_src_col,
    input  logic [nsc_pkg::CRD_W-1:0]  i_src_row,
    input  logic [nsc_pkg::PIX_W-1:0]  i_pixel_in,
    input  logic [nsc_pkg::CRD_W-1:0]  i_dst_x,
    input  logic [nsc_pkg::CRD_W-1:0]  i_dst_y,
    input  logic                       i_cfg_we,
    input  logic [nsc_pkg::IDX_W-1:0]  i_cfg_idx,
    input  logic [nsc_pkg::SIZE_W-1:0] i_cfg_data,
    output logic                       o_valid,
    output logic [nsc_pkg::PIX_W-1:0]  o_pixel_out,
    output logic                       o_from_cursor
);

    nsc_pkg::t_cfg             cfg;
    nsc_pkg::t_req             req;
    logic [nsc_pkg::PIX_W-1:0] rdata;
    logic                      accept;

    // pipeline takes a word every cycle
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // configuration
    nsc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_idx   (i_cfg_idx),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    // coordinate pipeline
    nsc_map u_map (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_cmd      (i_cmd),
        .i_src_col  (i_src_col),
        .i_src_row  (i_src_row),
        .i_pixel_in (i_pixel_in),
        .i_dst_x    (i_dst_x),
        .i_dst_y    (i_dst_y),
        .i_cfg      (cfg),
        .o_req      (req)
    );

    // source frame store
    nsc_ram #(
        .WIDTH (nsc_pkg::PIX_W),
        .DEPTH (nsc_pkg::DEPTH)
    ) u_frame (
        .i_clk   (i_clk),
        .i_we    (req.wr),
        .i_re    (req.rd),
        .i_addr  (req.addr),
        .i_wdata (req.wdata),
        .o_rdata (rdata)
    );

    // cursor overlay and output register
    nsc_out u_out (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req         (req),
        .i_cfg         (cfg),
        .i_rdata       (rdata),
        .o_valid       (o_valid),
        .o_pixel_out   (o_pixel_out),
        .o_from_cursor (o_from_cursor)
    );

endmodule

FILE: sv/nsc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsc_checker
// Port-level checks of the scaler: one result per read word at fixed
// latency, none for writes, and cursor pixels are opaque white.
// ----------------------------------------------------------------------------
module nsc_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      start,
    input logic                      busy,
    input logic                      i_cmd,
    input logic                      o_valid,
    input logic [nsc_pkg::PIX_W-1:0] o_pixel_out,
    input logic                      o_from_cursor
);

    // every read word gives a result after the pipeline latency
    a_read_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_cmd |-> ##(nsc_pkg::PIPE_LAT) o_valid)
        else $error("read word gave no result");

    // write words give no result
    a_write_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && !i_cmd |-> ##(nsc_pkg::PIPE_LAT) !o_valid)
        else $error("write word gave a result");

    // no result without a read word taken earlier
    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy && i_cmd, nsc_pkg::PIPE_LAT))
        else $error("result without a read word");

    // cursor pixels that come with a strobe are white
    a_cursor_white: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_from_cursor |-> o_pixel_out == nsc_pkg::WHITE_RGBA)
        else $error("cursor pixel is not white");

endmodule

bind nearest_scaler_with_cursor nsc_checker u_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .i_cmd         (i_cmd),
    .o_valid       (o_valid),
    .o_pixel_out   (o_pixel_out),
    .o_from_cursor (o_from_cursor)
);

FILE: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for nearest_scaler_with_cursor: a short directed run at
// the reset setting, then random traffic over a set of source sizes and
// cursor placements, checked word by word against a behavioral predictor.
// ----------------------------------------------------------------------------

// kind of an input word
typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_READ  = 1'b1
} t_word_cmd;

// one expected scaled pixel
typedef struct {
    logic [nsc_pkg::PIX_W-1:0] pixel;
    logic                      from_cursor;
} t_scaled_pixel;

class scaler_scoreboard;
    logic [nsc_pkg::SIZE_W-1:0] src_w;
    logic [nsc_pkg::SIZE_W-1:0] src_h;
    logic                       cursor_on;
    logic [nsc_pkg::CRD_W-1:0]  cursor_x;
    logic [nsc_pkg::CRD_W-1:0]  cursor_y;
    logic [nsc_pkg::PIX_W-1:0]  frame_words [int unsigned];
    t_scaled_pixel              pending_pixels [$];
    int                         errors;

    function new();
        src_w     = 11'd876;
        src_h     = 11'd700;
        cursor_on = 1'b1;
        cursor_x  = 10'd438;
        cursor_y  = 10'd350;
        errors    = 0;
    endfunction

    task report(string msg);
        $display("MISMATCH: %s", msg);
        errors++;
    endtask

    // zero counts as one, anything past the frame store as its full size
    function int unsigned clamp_dim(logic [nsc_pkg::SIZE_W-1:0] v, int unsigned lim);
        if (v == 0) return 1;
        if (v > lim) return lim;
        return v;
    endfunction

    function int unsigned eff_w();
        return clamp_dim(src_w, nsc_pkg::MAX_SRC_W);
    endfunction

    function int unsigned eff_h();
        return clamp_dim(src_h, nsc_pkg::MAX_SRC_H);
    endfunction

    function int unsigned frame_index(int unsigned col, int unsigned row);
        return row * nsc_pkg::MAX_SRC_W + col;
    endfunction

    function bit has_word(int unsigned col, int unsigned row);
        return frame_words.exists(frame_index(col, row));
    endfunction

    // arrow bitmap, bit n of a row is column n
    function logic [13:0] arrow_bits(int unsigned row);
        unique case (row)
            0:       return 14'h0001;
            1:       return 14'h0003;
            2:       return 14'h0007;
            3:       return 14'h000F;
            4:       return 14'h001F;
            5:       return 14'h003F;
            6:       return 14'h007F;
            7:       return 14'h00FF;
            8:       return 14'h01FF;
            9:       return 14'h003F;
            10:      return 14'h0067;
            11:      return 14'h00C3;
            12:      return 14'h0180;
            13:      return 14'h0080;
            default: return 14'h0000;
        endcase
    endfunction

    function bit under_cursor(int unsigned sx, int unsigned top);
        int unsigned col;
        int unsigned row;
        logic [13:0] bits;
        if (!cursor_on) return 0;
        if (sx < cursor_x || top < cursor_y) return 0;
        col = sx - cursor_x;
        row = top - cursor_y;
        if (col >= 14 || row >= 14) return 0;
        bits = arrow_bits(row);
        return bits[col];
    endfunction

    // destination point to bottom-up source cell, plus cursor coverage
    function void locate_source(input logic [nsc_pkg::CRD_W-1:0] dx,
                                input logic [nsc_pkg::CRD_W-1:0] dy,
                                output int unsigned sx, output int unsigned sy,
                                output bit hit);
        logic [63:0] t;
        int unsigned w;
        int unsigned h;
        w = eff_w();
        h = eff_h();
        t = 64'(dx) * 64'(w) / 64'(nsc_pkg::DST_W);
        sx = (t >= 64'(w)) ? w - 1 : int'(t);
        if (dy >= nsc_pkg::DST_H) begin
            sy = 0;
        end else begin
            t = 64'(nsc_pkg::DST_H - 1 - int'(dy)) * 64'(h) / 64'(nsc_pkg::DST_H);
            sy = (t >= 64'(h)) ? h - 1 : int'(t);
        end
        hit = under_cursor(sx, h - 1 - sy);
    endfunction

    function void set_register(nsc_pkg::t_cfg_idx idx, logic [nsc_pkg::SIZE_W-1:0] data);
        unique case (idx)
            nsc_pkg::CFG_SRC_W:     src_w     = data;
            nsc_pkg::CFG_SRC_H:     src_h     = data;
            nsc_pkg::CFG_CURSOR_ON: cursor_on = data[0];
            nsc_pkg::CFG_CURSOR_X:  cursor_x  = data[nsc_pkg::CRD_W-1:0];
            nsc_pkg::CFG_CURSOR_Y:  cursor_y  = data[nsc_pkg::CRD_W-1:0];
            default: ;
        endcase
    endfunction

    // accepted word: update the frame copy or queue the scaled pixel
    function void take_word(t_word_cmd cmd,
                            logic [nsc_pkg::CRD_W-1:0] col, logic [nsc_pkg::CRD_W-1:0] row,
                            logic [nsc_pkg::PIX_W-1:0] pix,
                            logic [nsc_pkg::CRD_W-1:0] dx, logic [nsc_pkg::CRD_W-1:0] dy);
        int unsigned sx;
        int unsigned sy;
        bit hit;
        t_scaled_pixel want;
        if (cmd == CMD_WRITE) begin
            if (col < eff_w() && row < eff_h()) frame_words[frame_index(col, row)] = pix;
        end else begin
            locate_source(dx, dy, sx, sy, hit);
            want.from_cursor = hit;
            if (hit) want.pixel = '1;  // opaque white
            else if (has_word(sx, sy)) want.pixel = frame_words[frame_index(sx, sy)];
            else want.pixel = '0;
            pending_pixels.push_back(want);
        end
    endfunction

    function int pending();
        return pending_pixels.size();
    endfunction

    task check_pixel(logic [nsc_pkg::PIX_W-1:0] pix, logic cur);
        t_scaled_pixel want;
        if (pending_pixels.size() == 0) begin
            report($sformatf("unexpected result pixel %h cursor %b", pix, cur));
            return;
        end
        want = pending_pixels.pop_front();
        if (pix !== want.pixel)
            report($sformatf("pixel %h, expected %h", pix, want.pixel));
        if (cur !== want.from_cursor)
            report($sformatf("from_cursor %b, expected %b", cur, want.from_cursor));
    endtask
endclass

module tb;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = nsc_pkg::PIPE_LAT + 3;
    localparam int PHASE_WORDS  = 160;
    localparam int NUM_PHASES   = 8;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n;
    logic                        start;
    logic                        busy;
    logic                        i_cmd;
    logic [nsc_pkg::CRD_W-1:0]   i_src_col;
    logic [nsc_pkg::CRD_W-1:0]   i_src_row;
    logic [nsc_pkg::PIX_W-1:0]   i_pixel_in;
    logic [nsc_pkg::CRD_W-1:0]   i_dst_x;
    logic [nsc_pkg::CRD_W-1:0]   i_dst_y;
    logic                        i_cfg_we;
    logic [nsc_pkg::IDX_W-1:0]   i_cfg_idx;
    logic [nsc_pkg::SIZE_W-1:0]  i_cfg_data;
    logic                        o_valid;
    logic [nsc_pkg::PIX_W-1:0]   o_pixel_out;
    logic                        o_from_cursor;

    scaler_scoreboard   sb;
    int                 cycle_cnt = 0;
    int                 idle_pct;
    int                 words_sent = 0;

    // phase settings: source size, cursor enable and placement
    int cfg_w  [NUM_PHASES] = '{1024, 1, 0,    37, 876, 2047, 500, 1000};
    int cfg_h  [NUM_PHASES] = '{1024, 1, 2047, 19, 700, 0,    300, 900};
    int cfg_on [NUM_PHASES] = '{1,    1, 0,    1,  0,   1,    1,   1};
    int cfg_cx [NUM_PHASES] = '{0,    0, 875,  30, 438, 0,    120, 875};
    int cfg_cy [NUM_PHASES] = '{0,    0, 699,  10, 350, 699,  280, 699};

    nearest_scaler_with_cursor i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_cmd         (i_cmd),
        .i_src_col     (i_src_col),
        .i_src_row     (i_src_row),
        .i_pixel_in    (i_pixel_in),
        .i_dst_x       (i_dst_x),
        .i_dst_y       (i_dst_y),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .o_valid       (o_valid),
        .o_pixel_out   (o_pixel_out),
        .o_from_cursor (o_from_cursor)
    );

    // clock
    always #5 i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) sb.check_pixel(o_pixel_out, o_from_cursor);
    end

    task automatic write_reg(nsc_pkg::t_cfg_idx idx, logic [nsc_pkg::SIZE_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        sb.set_register(idx, data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic configure(int w, int h, int on, int cx, int cy);
        write_reg(nsc_pkg::CFG_SRC_W, nsc_pkg::SIZE_W'(w));
        write_reg(nsc_pkg::CFG_SRC_H, nsc_pkg::SIZE_W'(h));
        write_reg(nsc_pkg::CFG_CURSOR_ON, nsc_pkg::SIZE_W'(on));
        write_reg(nsc_pkg::CFG_CURSOR_X, nsc_pkg::SIZE_W'(cx));
        write_reg(nsc_pkg::CFG_CURSOR_Y, nsc_pkg::SIZE_W'(cy));
    endtask

    // random sender idle before a word, each cycle idle with idle_pct odds
    task automatic sender_gap();
        while ($urandom_range(99) < idle_pct) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
    endtask

    // present one word and hold it until taken
    task automatic send_word(t_word_cmd cmd,
                             logic [nsc_pkg::CRD_W-1:0] col,
                             logic [nsc_pkg::CRD_W-1:0] row,
                             logic [nsc_pkg::PIX_W-1:0] pix,
                             logic [nsc_pkg::CRD_W-1:0] dx,
                             logic [nsc_pkg::CRD_W-1:0] dy);
        sender_gap();
        @(negedge i_clk);
        start      <= 1'b1;
        i_cmd      <= cmd;
        i_src_col  <= col;
        i_src_row  <= row;
        i_pixel_in <= pix;
        i_dst_x    <= dx;
        i_dst_y    <= dy;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sb.take_word(cmd, col, row, pix, dx, dy);
        words_sent++;
    endtask

    task automatic write_pixel(logic [nsc_pkg::CRD_W-1:0] col,
                               logic [nsc_pkg::CRD_W-1:0] row,
                               logic [nsc_pkg::PIX_W-1:0] pix);
        send_word(CMD_WRITE, col, row, pix,
                  nsc_pkg::CRD_W'($urandom), nsc_pkg::CRD_W'($urandom));
    endtask

    // read, first filling the target cell if it was never stored and the cursor does not cover it
    task automatic read_pixel(logic [nsc_pkg::CRD_W-1:0] dx, logic [nsc_pkg::CRD_W-1:0] dy);
        int unsigned sx;
        int unsigned sy;
        bit hit;
        sb.locate_source(dx, dy, sx, sy, hit);
        if (!hit && !sb.has_word(sx, sy))
            write_pixel(nsc_pkg::CRD_W'(sx), nsc_pkg::CRD_W'(sy), $urandom);
        send_word(CMD_READ, nsc_pkg::CRD_W'($urandom), nsc_pkg::CRD_W'($urandom),
                  $urandom, dx, dy);
    endtask

    // idle the sender and let every result come out
    task automatic drain();
        @(negedge i_clk);
        start <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // one random write or read, a read may bring its fill write along
    task automatic random_word();
        int unsigned r;
        int unsigned w;
        int unsigned h;
        int unsigned sx_t;
        int unsigned top;
        int unsigned dx;
        int unsigned dy;
        logic [nsc_pkg::CRD_W-1:0] col;
        logic [nsc_pkg::CRD_W-1:0] row;
        w = sb.eff_w();
        h = sb.eff_h();
        r = $urandom_range(99);
        if (r < 20) begin
            // write, half inside the source and half anywhere
            if ($urandom_range(1)) begin
                col = nsc_pkg::CRD_W'($urandom_range(w - 1));
                row = nsc_pkg::CRD_W'($urandom_range(h - 1));
            end else begin
                col = nsc_pkg::CRD_W'($urandom_range(1023));
                row = nsc_pkg::CRD_W'($urandom_range(1023));
            end
            write_pixel(col, row, $urandom);
        end else begin
            if (r < 35) begin
                // whole field range, past the destination edge too
                dx = $urandom_range(1023);
                dy = $urandom_range(1023);
            end else if (r < 60 && sb.cursor_on) begin
                // aim at the arrow and its surroundings
                sx_t = sb.cursor_x + $urandom_range(15);
                top  = sb.cursor_y + $urandom_range(15);
                dx   = sx_t * nsc_pkg::DST_W / w;
                if (dx > 1023) dx = 1023;
                if (top < h) dy = nsc_pkg::DST_H - 1 - ((h - 1 - top) * nsc_pkg::DST_H / h);
                else dy = $urandom_range(nsc_pkg::DST_H - 1);
            end else begin
                dx = $urandom_range(nsc_pkg::DST_W - 1);
                dy = $urandom_range(nsc_pkg::DST_H - 1);
            end
            read_pixel(nsc_pkg::CRD_W'(dx), nsc_pkg::CRD_W'(dy));
        end
    endtask

    // random traffic until the phase has sent its share of words
    task automatic run_phase(int words);
        int stop;
        stop = words_sent + words;
        while (words_sent < stop) random_word();
    endtask

    initial begin
        sb         = new();
        i_rst_n    = 1'b0;
        start      = 1'b0;
        i_cmd      = CMD_WRITE;
        i_src_col  = '0;
        i_src_row  = '0;
        i_pixel_in = '0;
        i_dst_x    = '0;
        i_dst_y    = '0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = nsc_pkg::CFG_SRC_W;
        i_cfg_data = '0;
        idle_pct   = 7;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // corners at the reset setting, 876 x 700 with the cursor at its middle
        write_pixel(0, 0, 32'h0000_0000);
        write_pixel(875, 699, 32'hFFFF_FFFF);
        write_pixel(0, 699, 32'hA5A5_A5A5);
        write_pixel(875, 0, 32'h5A5A_5A5A);
        // writes past the source edge are dropped
        write_pixel(876, 5, 32'hDEAD_0001);
        write_pixel(5, 700, 32'hDEAD_0002);
        write_pixel(1023, 1023, 32'hDEAD_0003);
        read_pixel(0, 0);
        read_pixel(875, 699);
        read_pixel(0, 699);
        read_pixel(875, 0);
        // past the destination edge: column clamps, row goes to the bottom
        read_pixel(1023, 1023);
        read_pixel(1023, 0);
        read_pixel(0, 1023);
        // arrow tip, a gap beside it, a filled cell and the tail
        read_pixel(438, 350);
        read_pixel(439, 350);
        read_pixel(446, 358);
        read_pixel(447, 358);
        read_pixel(445, 362);
        read_pixel(451, 363);
        drain();

        // random phases: low sender idling, then heavy, then none
        for (int p = 0; p < NUM_PHASES; p++) begin
            configure(cfg_w[p], cfg_h[p], cfg_on[p], cfg_cx[p], cfg_cy[p]);
            if (p < 3) idle_pct = 7;
            else if (p < 6) idle_pct = 48;
            else idle_pct = 0;
            run_phase(PHASE_WORDS);
            drain();
        end

        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
